// ----- rtl/core/sust_pkg.sv -----
// ----------------------------------------------------------------------------
// sust_pkg: shared types and constants for the sorted unique set table
// Table depth, field widths, operation and status codes, cell interface.
// ----------------------------------------------------------------------------
`default_nettype none

package sust_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [1:0] {
        KIND_INSERT   = 2'd0,
        KIND_REMOVE   = 2'd1,
        KIND_GET      = 2'd2,
        KIND_CONTAINS = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Per-cell update command, driven by the table control.
    typedef struct packed {
        logic valid;       // cell lies below the fill count
        logic load_val;    // take the operand value
        logic take_left;   // take the lower neighbour's entry
        logic take_right;  // take the upper neighbour's entry
    } cell_ctrl_t;

    // Per-cell compare results.
    typedef struct packed {
        logic match;       // valid entry equals the operand
        logic at_or_above; // entry is empty or larger than the operand
    } cell_flags_t;

endpackage

`default_nettype wire

// ----- rtl/core/sust_cell.sv -----
// ----------------------------------------------------------------------------
// sust_cell: one slot of the sorted table
// Holds one entry, compares it with the operand and shifts towards either
// neighbour on command.
// ----------------------------------------------------------------------------
`default_nettype none

module sust_cell (
    input  wire                                  aclk,
    input  wire sust_pkg::cell_ctrl_t            ctrl,
    input  wire logic signed [sust_pkg::DATA_W-1:0] op_value,
    input  wire logic signed [sust_pkg::DATA_W-1:0] left_value,
    input  wire logic signed [sust_pkg::DATA_W-1:0] right_value,
    output logic signed [sust_pkg::DATA_W-1:0]   entry_value,
    output sust_pkg::cell_flags_t                flags
);

    logic signed [sust_pkg::DATA_W-1:0] entry_reg;
    logic signed [sust_pkg::DATA_W-1:0] entry_next;

    always_comb begin
        flags.match       = ctrl.valid && (entry_reg == op_value);
        flags.at_or_above = !ctrl.valid || (op_value < entry_reg);
    end

    always_comb begin
        priority if (ctrl.load_val) begin
            entry_next = op_value;
        end else if (ctrl.take_left) begin
            entry_next = left_value;
        end else if (ctrl.take_right) begin
            entry_next = right_value;
        end else begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_value = entry_reg;

endmodule

`default_nettype wire

// ----- rtl/core/sorted_unique_set_table.sv -----
// ----------------------------------------------------------------------------
// sorted_unique_set_table: ascending set of signed values without duplicates
// Insert, remove by position, read by position and membership test over a
// row of compare-and-shift cells.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake          | Payload
//  s_       | in        | s_valid / s_ready  | kind, value, position
//  m_       | out       | m_valid / m_ready  | read_value, present, count, status
//
//  Every cell compares its entry with the operand at once and shifts in the
//  same edge, so one operation a cycle while s_ready is high.
//  The result appears in the output register the cycle after acceptance.
//  s_ready is low in reset, otherwise high while the output register is empty
//  or being drained.
//  Reset clears the fill count and the output valid; cell contents stay
//  undefined and are read only below the count.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_unique_set_table (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  wire  [1:0]                           s_kind,
    input  wire logic signed [sust_pkg::DATA_W-1:0] s_value,
    input  wire  [sust_pkg::CNT_W-1:0]           s_position,
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output logic signed [sust_pkg::DATA_W-1:0]   m_read_value,
    output logic                                 m_present,
    output logic [sust_pkg::CNT_W-1:0]           m_count,
    output logic [1:0]                           m_status
);

    localparam int DEPTH = sust_pkg::DEPTH;
    localparam int CNT_W = sust_pkg::CNT_W;

    logic signed [sust_pkg::DATA_W-1:0] entry_val [DEPTH];
    sust_pkg::cell_ctrl_t               ctrl      [DEPTH];
    sust_pkg::cell_flags_t              flags     [DEPTH];
    logic [DEPTH-1:0]                   match_vec;
    logic [DEPTH-1:0]                   aoa_vec;
    logic [DEPTH-1:0]                   slot_vec;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic                               m_valid_reg;
    logic                               m_valid_next;
    logic signed [sust_pkg::DATA_W-1:0] read_value_reg;
    logic signed [sust_pkg::DATA_W-1:0] read_value_next;
    logic                               present_reg;
    logic                               present_next;
    logic [CNT_W-1:0]                   m_count_reg;
    sust_pkg::status_t                  status_reg;
    sust_pkg::status_t                  status_next;

    sust_pkg::kind_t     kind;
    logic                accept;
    logic                present_any;
    logic                full;
    logic                pos_bad;
    logic                do_ins;
    logic                do_rem;
    logic [sust_pkg::ADDR_W-1:0] rd_idx;

    assign kind        = sust_pkg::kind_t'(s_kind);
    assign s_ready     = aresetn && (!m_valid_reg || m_ready);
    assign accept      = s_valid && s_ready;
    assign present_any = |match_vec;
    assign full        = (count_reg == CNT_W'(DEPTH));
    assign pos_bad     = (s_position == '0) || (s_position > count_reg);
    assign do_ins      = accept && (kind == sust_pkg::KIND_INSERT) && !present_any && !full;
    assign do_rem      = accept && (kind == sust_pkg::KIND_REMOVE) && !pos_bad;
    assign rd_idx      = sust_pkg::ADDR_W'(s_position - 1'b1);

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            logic signed [sust_pkg::DATA_W-1:0] left_v;
            logic signed [sust_pkg::DATA_W-1:0] right_v;

            assign match_vec[i] = flags[i].match;
            assign aoa_vec[i]   = flags[i].at_or_above;

            // The insertion slot is the first cell at or above the operand.
            if (i == 0) begin : g_first
                assign slot_vec[i] = aoa_vec[i];
                assign left_v      = entry_val[i];
            end else begin : g_rest
                assign slot_vec[i] = aoa_vec[i] && !aoa_vec[i-1];
                assign left_v      = entry_val[i-1];
            end

            if (i == DEPTH - 1) begin : g_last
                assign right_v = entry_val[i];
            end else begin : g_inner
                assign right_v = entry_val[i+1];
            end

            always_comb begin
                ctrl[i].valid      = (CNT_W'(i) < count_reg);
                ctrl[i].load_val   = do_ins && slot_vec[i];
                ctrl[i].take_left  = do_ins && aoa_vec[i] && !slot_vec[i];
                ctrl[i].take_right = do_rem && (CNT_W'(i + 1) >= s_position);
            end

            sust_cell u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl[i]),
                .op_value    (s_value),
                .left_value  (left_v),
                .right_value (right_v),
                .entry_value (entry_val[i]),
                .flags       (flags[i])
            );
        end
    endgenerate

    always_comb begin
        count_next      = count_reg;
        read_value_next = '0;
        present_next    = 1'b0;
        status_next     = sust_pkg::ST_OK;
        unique case (kind)
            sust_pkg::KIND_INSERT: begin
                present_next = present_any;
                if (present_any) begin
                    status_next = sust_pkg::ST_DUP;
                end else if (full) begin
                    status_next = sust_pkg::ST_FULL;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
            sust_pkg::KIND_REMOVE: begin
                if (pos_bad) begin
                    status_next = sust_pkg::ST_RANGE;
                end else begin
                    count_next = count_reg - 1'b1;
                end
            end
            sust_pkg::KIND_GET: begin
                if (pos_bad) begin
                    status_next = sust_pkg::ST_RANGE;
                end else begin
                    read_value_next = entry_val[rd_idx];
                end
            end
            sust_pkg::KIND_CONTAINS: begin
                present_next = present_any;
            end
            default: begin
                status_next = sust_pkg::ST_OK;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (accept) begin
                count_reg <= count_next;
            end
        end
    end

    // Hold the result until the downstream side takes it.
    always_ff @(posedge aclk) begin
        if (accept) begin
            read_value_reg <= read_value_next;
            present_reg    <= present_next;
            m_count_reg    <= count_next;
            status_reg     <= status_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = read_value_reg;
    assign m_present    = present_reg;
    assign m_count      = m_count_reg;
    assign m_status     = status_reg;

endmodule

`default_nettype wire
